FILE: src/sqt_pkg.sv
// Shared types, codes, character classes and keyword table of the SQL tokenizer.
package sqt_pkg;

	// Keyword matching covers this many leading bytes of a word
	localparam int KW_CHARS     = 8;
	localparam int NUM_KEYWORDS = 22;
	localparam int MAX_RESULTS  = 3;

	// Lexer modes
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_WORD   = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_STRING = 3'd3;
	localparam logic [2:0] MODE_DRAIN  = 3'd4;

	// Token kinds
	localparam logic [3:0] KIND_KEYWORD = 4'd0;
	localparam logic [3:0] KIND_IDENT   = 4'd1;
	localparam logic [3:0] KIND_NUMBER  = 4'd2;
	localparam logic [3:0] KIND_STRING  = 4'd3;
	localparam logic [3:0] KIND_LPAREN  = 4'd4;
	localparam logic [3:0] KIND_RPAREN  = 4'd5;
	localparam logic [3:0] KIND_COMMA   = 4'd6;
	localparam logic [3:0] KIND_SEMI    = 4'd7;
	localparam logic [3:0] KIND_STAR    = 4'd8;
	localparam logic [3:0] KIND_EQUAL   = 4'd9;
	localparam logic [3:0] KIND_LESS    = 4'd10;
	localparam logic [3:0] KIND_GREATER = 4'd11;
	localparam logic [3:0] KIND_INVALID = 4'd12;
	localparam logic [3:0] KIND_END     = 4'd13;

	// Characters with a meaning of their own
	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_STAR       = 8'h2A;
	localparam logic [7:0] CH_COMMA      = 8'h2C;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_SEMI       = 8'h3B;
	localparam logic [7:0] CH_LESS       = 8'h3C;
	localparam logic [7:0] CH_EQUAL      = 8'h3D;
	localparam logic [7:0] CH_GREATER    = 8'h3E;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_CASE_GAP   = 8'h20;

	// Keyword text, first character in the top byte, zero padded below
	localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
		{"CREATE", 16'h0}, {"TABLE", 24'h0}, {"INSERT", 16'h0}, {"INTO", 32'h0},
		{"VALUES", 16'h0}, {"UPDATE", 16'h0}, {"SET", 40'h0}, {"DELETE", 16'h0},
		{"FROM", 32'h0}, {"WHERE", 24'h0}, {"SELECT", 16'h0}, {"VERSION", 8'h0},
		"ROLLBACK", {"DROP", 32'h0}, {"INDEX", 24'h0}, {"ON", 48'h0},
		{"HISTORY", 8'h0}, {"HELP", 32'h0}, {"INT", 40'h0}, {"DOUBLE", 16'h0},
		{"STRING", 16'h0}, {"BOOL", 32'h0}
	};

	// One token on the output side
	typedef struct packed {
		logic [3:0]  token_kind;
		logic [4:0]  keyword_index;
		logic [11:0] start_offset;
		logic [12:0] token_length;
		logic [7:0]  odd_byte;
		logic        last_of_run;
	} result_t;

	// A candidate token inside the lexer
	typedef struct packed {
		logic    valid;
		result_t res;
	} slot_t;

	// All tokens caused by one byte
	typedef struct packed {
		logic [1:0]                   cnt;
		result_t [MAX_RESULTS-1:0]    item;
	} burst_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] idx;
	} kw_hit_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c inside {CH_SPACE, [CH_TAB:CH_CR]};
	endfunction

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A]}) ? c - CH_CASE_GAP : c;
	endfunction

	// Punctuation kind, or invalid for any other byte
	function automatic logic [3:0] punct_kind(input logic [7:0] c);
		logic [3:0] k;
		case (c)
			CH_LPAREN:  k = KIND_LPAREN;
			CH_RPAREN:  k = KIND_RPAREN;
			CH_COMMA:   k = KIND_COMMA;
			CH_SEMI:    k = KIND_SEMI;
			CH_STAR:    k = KIND_STAR;
			CH_EQUAL:   k = KIND_EQUAL;
			CH_LESS:    k = KIND_LESS;
			CH_GREATER: k = KIND_GREATER;
			default:    k = KIND_INVALID;
		endcase
		return k;
	endfunction

	// Swap byte order so byte 0 lands in the top byte
	function automatic logic [63:0] byte_rev(input logic [63:0] w);
		logic [63:0] r;
		for (int i = 0; i < KW_CHARS; i++) begin
			r[8*i +: 8] = w[8*(KW_CHARS-1-i) +: 8];
		end
		return r;
	endfunction

	// Compare a word buffer (byte i at bits 8*i) against every keyword
	function automatic kw_hit_t kw_lookup(input logic [63:0] wbuf);
		kw_hit_t     h;
		logic [63:0] rev;
		h   = '0;
		rev = byte_rev(wbuf);
		for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
			if (KW_TEXT[i] == rev) begin
				h.hit = 1'b1;
				h.idx = 5'(i);
			end
		end
		return h;
	endfunction

endpackage

FILE: src/sqt_lexer.sv
// Lexer state registers and the single-pass token logic for one byte.
module sqt_lexer import sqt_pkg::*; #(
	parameter int MAX_QUERY = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       end_of_query,
	output burst_t     burst
);

	localparam int POS_W = $clog2(MAX_QUERY);
	localparam int CNT_W = $clog2(MAX_QUERY + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_QUERY - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_QUERY);

	logic [2:0]       mode_q,  nxt_mode;
	logic [POS_W-1:0] pos_q,   nxt_pos;
	logic [POS_W-1:0] start_q, nxt_start;
	logic [CNT_W-1:0] cnt_q,   nxt_cnt;
	logic [63:0]      wbuf_q,  nxt_wbuf;
	logic             long_q,  nxt_long;

	logic [POS_W-1:0] pos_inc;
	logic [CNT_W-1:0] cnt_inc;
	logic [63:0]      wbuf_add;
	logic             long_add;
	logic [7:0]       up;
	logic             do_idle;
	slot_t            close1, emit_b, close2, end_tok;
	slot_t            close_cur, close_nxt;
	slot_t [3:0]      slots;
	logic [1:0]       n;

	// Close the open token, if any, into a candidate result
	function automatic slot_t close_tok(input logic [2:0] mode,
			input logic [POS_W-1:0] start, input logic [CNT_W-1:0] cnt,
			input logic [63:0] wbuf, input logic too_long);
		slot_t   s;
		kw_hit_t h;
		h = kw_lookup(wbuf);
		s = '0;
		s.res.start_offset = 12'(start);
		s.res.token_length = 13'(cnt);
		case (mode)
			MODE_WORD: begin
				s.valid = 1'b1;
				if (!too_long && h.hit) begin
					s.res.token_kind    = KIND_KEYWORD;
					s.res.keyword_index = h.idx;
				end else begin
					s.res.token_kind = KIND_IDENT;
				end
			end
			MODE_NUMBER: begin
				s.valid          = 1'b1;
				s.res.token_kind = KIND_NUMBER;
			end
			MODE_STRING: begin
				s.valid          = 1'b1;
				s.res.token_kind = KIND_STRING;
			end
			default: s.valid = 1'b0;
		endcase
		return s;
	endfunction

	// Saturating increments and the word buffer with this byte appended
	always_comb begin
		up       = to_upper(in_byte);
		pos_inc  = (pos_q < POS_MAX) ? pos_q + 1'b1 : POS_MAX;
		cnt_inc  = (cnt_q < CNT_MAX) ? cnt_q + 1'b1 : CNT_MAX;
		wbuf_add = wbuf_q;
		long_add = long_q;
		if (cnt_q < CNT_W'(KW_CHARS)) begin
			for (int i = 0; i < KW_CHARS; i++) begin
				if (cnt_q[2:0] == 3'(i)) begin
					wbuf_add[8*i +: 8] = up;
				end
			end
		end else begin
			long_add = 1'b1;
		end
	end

	assign close_cur = close_tok(mode_q, start_q, cnt_q, wbuf_q, long_q);

	// Next state and the candidate tokens for this byte
	always_comb begin
		nxt_mode  = mode_q;
		nxt_pos   = pos_q;
		nxt_start = start_q;
		nxt_cnt   = cnt_q;
		nxt_wbuf  = wbuf_q;
		nxt_long  = long_q;
		close1    = '0;
		emit_b    = '0;
		close2    = '0;
		end_tok   = '0;
		close_nxt = '0;
		do_idle   = 1'b0;

		end_tok.res.token_kind = KIND_END;

		if (mode_q == MODE_DRAIN) begin
			// drop bytes until the query's last flag
			if (end_of_query) begin
				nxt_mode  = MODE_IDLE;
				nxt_pos   = '0;
				nxt_start = '0;
				nxt_cnt   = '0;
				nxt_wbuf  = '0;
				nxt_long  = 1'b0;
			end
		end else if (in_byte == CH_NUL) begin
			// zero byte ends the query at its own offset
			close1                   = close_cur;
			end_tok.valid            = 1'b1;
			end_tok.res.start_offset = 12'(pos_q);
			nxt_mode  = end_of_query ? MODE_IDLE : MODE_DRAIN;
			nxt_pos   = '0;
			nxt_start = '0;
			nxt_cnt   = '0;
			nxt_wbuf  = '0;
			nxt_long  = 1'b0;
		end else begin
			case (mode_q)
				MODE_WORD: begin
					if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == CH_UNDERSCORE) begin
						nxt_cnt  = cnt_inc;
						nxt_wbuf = wbuf_add;
						nxt_long = long_add;
					end else begin
						close1  = close_cur;
						do_idle = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit(in_byte) || in_byte == CH_DOT) begin
						nxt_cnt = cnt_inc;
					end else begin
						close1  = close_cur;
						do_idle = 1'b1;
					end
				end
				MODE_STRING: begin
					if (in_byte == CH_QUOTE) begin
						close1   = close_cur;
						nxt_mode = MODE_IDLE;
					end else begin
						nxt_cnt = cnt_inc;
					end
				end
				default: do_idle = 1'b1;
			endcase

			// start a token or emit a one-byte token from idle
			if (do_idle) begin
				nxt_mode = MODE_IDLE;
				if (is_space(in_byte)) begin
					nxt_mode = MODE_IDLE;
				end else if (is_alpha(in_byte) || in_byte == CH_UNDERSCORE) begin
					nxt_mode  = MODE_WORD;
					nxt_start = pos_q;
					nxt_cnt   = CNT_W'(1);
					nxt_wbuf  = 64'(up);
					nxt_long  = 1'b0;
				end else if (is_digit(in_byte)) begin
					nxt_mode  = MODE_NUMBER;
					nxt_start = pos_q;
					nxt_cnt   = CNT_W'(1);
					nxt_wbuf  = '0;
					nxt_long  = 1'b0;
				end else if (in_byte == CH_QUOTE) begin
					nxt_mode  = MODE_STRING;
					nxt_start = pos_inc;
					nxt_cnt   = '0;
					nxt_wbuf  = '0;
					nxt_long  = 1'b0;
				end else begin
					emit_b.valid            = 1'b1;
					emit_b.res.token_kind   = punct_kind(in_byte);
					emit_b.res.start_offset = 12'(pos_q);
					emit_b.res.token_length = 13'd1;
					emit_b.res.odd_byte     = in_byte;
				end
			end

			nxt_pos = pos_inc;

			// last byte: close what is open and end the query
			if (end_of_query) begin
				close_nxt                = close_tok(nxt_mode, nxt_start, nxt_cnt,
					nxt_wbuf, nxt_long);
				close2                   = close_nxt;
				end_tok.valid            = 1'b1;
				end_tok.res.start_offset = 12'(pos_inc);
				nxt_mode  = MODE_IDLE;
				nxt_pos   = '0;
				nxt_start = '0;
				nxt_cnt   = '0;
				nxt_wbuf  = '0;
				nxt_long  = 1'b0;
			end
		end
	end

	// Pack the valid candidates in order and mark the last one
	always_comb begin
		slots      = {end_tok, close2, emit_b, close1};
		burst.item = '0;
		n          = 2'd0;
		for (int k = 0; k < 4; k++) begin
			if (slots[k].valid && n != 2'(MAX_RESULTS)) begin
				burst.item[n] = slots[k].res;
				n             = n + 2'd1;
			end
		end
		if (n != 2'd0) begin
			burst.item[n - 2'd1].last_of_run = 1'b1;
		end
		burst.cnt = n;
	end

	// Advance the lexer state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			cnt_q   <= '0;
			wbuf_q  <= '0;
			long_q  <= 1'b0;
		end else if (accept) begin
			mode_q  <= nxt_mode;
			pos_q   <= nxt_pos;
			start_q <= nxt_start;
			cnt_q   <= nxt_cnt;
			wbuf_q  <= nxt_wbuf;
			long_q  <= nxt_long;
		end
	end

endmodule

FILE: src/sqt_outbuf.sv
// Result register bank that hands out the tokens of one byte one per transfer.
module sqt_outbuf import sqt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  burst_t  burst,
	output logic    can_load,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	result_t [MAX_RESULTS-1:0] items_q;
	logic [1:0]                rem_q;
	logic [1:0]                head_q;
	logic                      pop;

	// Take a new burst when nothing is pending or the last pending token leaves this cycle
	assign out_valid = (rem_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign can_load  = (rem_q == 2'd0) || (rem_q == 2'd1 && out_ready);
	assign out_res   = items_q[head_q];

	// Track the pending count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= 2'd0;
			head_q <= 2'd0;
		end else if (load) begin
			rem_q  <= burst.cnt;
			head_q <= 2'd0;
		end else if (pop) begin
			rem_q  <= rem_q - 2'd1;
			head_q <= head_q + 2'd1;
		end
	end

	// Hold the token payloads
	always_ff @(posedge clk) begin
		if (load) begin
			items_q <= burst.item;
		end
	end

endmodule

FILE: src/sql_query_tokenizer_core.sv
// Output: the first token of a byte is registered and appears in the cycle after the byte is transferred in.
// Throughput: one byte per cycle while each byte yields at most one token and the output
// is ready; a byte yielding two or three tokens holds the input until the result bank
// is down to its last token, as the single output port drains it one token per transfer.
// Reset: arst_n clears the lexer mode, offsets, word buffer and pending-token count.
module sql_query_tokenizer_core import sqt_pkg::*; #(
	parameter int MAX_QUERY = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // end_of_query
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [3:0] token_kind, [8:4] keyword_index,
	                                    // [20:9] start_offset, [33:21] token_length,
	                                    // [41:34] odd_byte, [47:42] zero
	output logic        m_axis_tlast    // last_of_run
);

	logic    accept;
	logic    can_load;
	burst_t  burst;
	result_t out_res;

	assign s_axis_tready = can_load;
	assign accept        = s_axis_tvalid && can_load;

	// Tokenize each accepted byte
	sqt_lexer #(
		.MAX_QUERY (MAX_QUERY)
	) u_lexer (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (s_axis_tdata),
		.end_of_query (s_axis_tlast),
		.burst        (burst)
	);

	// Register the tokens and hand them out in order
	sqt_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.burst     (burst),
		.can_load  (can_load),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// Pack the output transfer
	assign m_axis_tdata = {6'b0, out_res.odd_byte, out_res.token_length,
		out_res.start_offset, out_res.keyword_index, out_res.token_kind};
	assign m_axis_tlast = out_res.last_of_run;

endmodule

FILE: tb/sql_query_tokenizer_core_tb.sv
// Self-checking testbench for the streaming SQL query tokenizer core.
`timescale 1ns / 100ps

module sql_query_tokenizer_core_tb;
	import sqt_pkg::*;

	localparam int QUERY_MAX   = 4096;
	localparam logic [11:0] OFFSET_TOP = 12'(QUERY_MAX - 1);
	localparam int STUCK_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] in_byte
	logic        s_axis_tlast = 1'b0; // end_of_query
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // [3:0] kind, [8:4] keyword, [20:9] start,
	                                  // [33:21] length, [41:34] odd_byte, [47:42] zero
	logic        m_axis_tlast;        // last_of_run

	sql_query_tokenizer_core #(.MAX_QUERY(QUERY_MAX)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	string kw_names [NUM_KEYWORDS] = '{
		"CREATE", "TABLE", "INSERT", "INTO", "VALUES", "UPDATE", "SET", "DELETE",
		"FROM", "WHERE", "SELECT", "VERSION", "ROLLBACK", "DROP", "INDEX", "ON",
		"HISTORY", "HELP", "INT", "DOUBLE", "STRING", "BOOL"
	};
	logic [7:0] punct_chars [8] = '{
		CH_LPAREN, CH_RPAREN, CH_COMMA, CH_SEMI, CH_STAR, CH_EQUAL, CH_LESS, CH_GREATER
	};

	// Lexer shadow state
	logic [2:0]  lx_mode;
	logic [11:0] lx_pos;
	logic [11:0] lx_start;
	logic [12:0] lx_len;
	logic [63:0] lx_word;
	logic        lx_long;

	result_t     run_toks[$];
	result_t     token_q[$];

	int  err_count = 0;
	int  tok_seen = 0;
	int  stuck = 0;
	int  rx_hold = 0;
	bit  tx_nogap = 1'b0;
	bit  rx_nogap = 1'b0;

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Token predictor
	// ---------------------------------------------------------------
	function automatic bit char_is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit char_is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit char_is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [11:0] offset_next(input logic [11:0] p);
		return (p < OFFSET_TOP) ? p + 12'd1 : OFFSET_TOP;
	endfunction

	function automatic void add_token(input logic [3:0] kind, input logic [4:0] kw,
			input logic [11:0] start, input logic [12:0] len, input logic [7:0] odd);
		result_t t;
		t.token_kind    = kind;
		t.keyword_index = kw;
		t.start_offset  = start;
		t.token_length  = len;
		t.odd_byte      = odd;
		t.last_of_run   = 1'b0;
		run_toks.insert(run_toks.size(), t);
	endfunction

	// Index of the keyword held in the word buffer, or -1
	function automatic int keyword_of(input logic [63:0] w);
		int hit;
		logic [63:0] kw_bits;
		hit = -1;
		for (int i = 0; i < NUM_KEYWORDS; i++) begin
			kw_bits = '0;
			for (int j = 0; j < kw_names[i].len(); j++)
				kw_bits[8*j +: 8] = kw_names[i][j];
			if (hit < 0 && kw_bits == w)
				hit = i;
		end
		return hit;
	endfunction

	function automatic void clear_lexer();
		lx_mode  = MODE_IDLE;
		lx_pos   = '0;
		lx_start = '0;
		lx_len   = '0;
		lx_word  = '0;
		lx_long  = 1'b0;
	endfunction

	function automatic void open_token(input logic [2:0] mode, input logic [11:0] start);
		lx_mode  = mode;
		lx_start = start;
		lx_len   = '0;
		lx_word  = '0;
		lx_long  = 1'b0;
	endfunction

	function automatic void count_char();
		if (lx_len < 13'(QUERY_MAX))
			lx_len = lx_len + 13'd1;
	endfunction

	// Fold into upper case and keep the first keyword-width bytes
	function automatic void take_word_char(input logic [7:0] c);
		logic [7:0] up;
		up = (c >= "a" && c <= "z") ? c - 8'h20 : c;
		if (lx_len < 13'(KW_CHARS))
			lx_word[8*lx_len +: 8] = up;
		else
			lx_long = 1'b1;
		count_char();
	endfunction

	function automatic void close_open();
		int k;
		case (lx_mode)
			MODE_WORD: begin
				k = lx_long ? -1 : keyword_of(lx_word);
				if (k >= 0)
					add_token(KIND_KEYWORD, 5'(k), lx_start, lx_len, 8'h00);
				else
					add_token(KIND_IDENT, 5'd0, lx_start, lx_len, 8'h00);
			end
			MODE_NUMBER: add_token(KIND_NUMBER, 5'd0, lx_start, lx_len, 8'h00);
			MODE_STRING: add_token(KIND_STRING, 5'd0, lx_start, lx_len, 8'h00);
			default: ;
		endcase
		lx_mode = MODE_IDLE;
	endfunction

	// Lex a byte that arrives between tokens
	function automatic void lex_fresh(input logic [7:0] c, input logic [11:0] p);
		logic [3:0] kind;
		if (char_is_blank(c))
			return;
		if (char_is_letter(c) || c == CH_UNDERSCORE) begin
			open_token(MODE_WORD, p);
			take_word_char(c);
		end else if (char_is_digit(c)) begin
			open_token(MODE_NUMBER, p);
			count_char();
		end else if (c == CH_QUOTE) begin
			open_token(MODE_STRING, offset_next(p));
		end else begin
			case (c)
				CH_LPAREN:  kind = KIND_LPAREN;
				CH_RPAREN:  kind = KIND_RPAREN;
				CH_COMMA:   kind = KIND_COMMA;
				CH_SEMI:    kind = KIND_SEMI;
				CH_STAR:    kind = KIND_STAR;
				CH_EQUAL:   kind = KIND_EQUAL;
				CH_LESS:    kind = KIND_LESS;
				CH_GREATER: kind = KIND_GREATER;
				default:    kind = KIND_INVALID;
			endcase
			add_token(kind, 5'd0, p, 13'd1, c);
		end
	endfunction

	// Work out the tokens one accepted byte causes and queue them
	function automatic void predict_byte(input logic [7:0] c, input logic fl);
		logic [11:0] p;
		p = lx_pos;
		run_toks.delete();
		if (lx_mode == MODE_DRAIN) begin
			if (fl)
				clear_lexer();
		end else if (c == CH_NUL) begin
			close_open();
			add_token(KIND_END, 5'd0, p, 13'd0, 8'h00);
			clear_lexer();
			if (!fl)
				lx_mode = MODE_DRAIN;
		end else begin
			case (lx_mode)
				MODE_WORD:
					if (char_is_letter(c) || char_is_digit(c) || c == CH_UNDERSCORE)
						take_word_char(c);
					else begin
						close_open();
						lex_fresh(c, p);
					end
				MODE_NUMBER:
					if (char_is_digit(c) || c == CH_DOT)
						count_char();
					else begin
						close_open();
						lex_fresh(c, p);
					end
				MODE_STRING:
					if (c == CH_QUOTE)
						close_open();
					else
						count_char();
				default: lex_fresh(c, p);
			endcase
			lx_pos = offset_next(p);
			if (fl) begin
				close_open();
				add_token(KIND_END, 5'd0, lx_pos, 13'd0, 8'h00);
				clear_lexer();
			end
		end
		if (run_toks.size() > 0)
			run_toks[run_toks.size()-1].last_of_run = 1'b1;
		foreach (run_toks[i])
			token_q.insert(token_q.size(), run_toks[i]);
	endfunction

	// ---------------------------------------------------------------
	// Input side
	// ---------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic fl);
		int gap;
		gap = tx_nogap ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= fl;
		do @(posedge clk); while (!s_axis_tready);
		predict_byte(b, fl);
	endtask

	task automatic send_text(input string s, input bit fl);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], fl && (i == s.len() - 1));
	endtask

	// ---------------------------------------------------------------
	// Output side
	// ---------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		err_count++;
		$display("%0t: token %0d %s: got %0d, expected %0d", $realtime, tok_seen, what,
			got, want);
	endtask

	task automatic check_token(input logic [47:0] d, input logic l);
		result_t want;
		tok_seen++;
		if (token_q.size() == 0) begin
			report_mismatch("arrived with none pending, kind", 16'(d[3:0]), 16'd0);
		end else begin
			want = token_q.pop_front();
			if (d[3:0] !== want.token_kind)
				report_mismatch("kind", 16'(d[3:0]), 16'(want.token_kind));
			if (d[8:4] !== want.keyword_index)
				report_mismatch("keyword", 16'(d[8:4]), 16'(want.keyword_index));
			if (d[20:9] !== want.start_offset)
				report_mismatch("start", 16'(d[20:9]), 16'(want.start_offset));
			if (d[33:21] !== want.token_length)
				report_mismatch("length", 16'(d[33:21]), 16'(want.token_length));
			if (d[41:34] !== want.odd_byte)
				report_mismatch("odd_byte", 16'(d[41:34]), 16'(want.odd_byte));
			if (d[47:42] !== 6'd0)
				report_mismatch("pad bits", 16'(d[47:42]), 16'd0);
			if (l !== want.last_of_run)
				report_mismatch("last", 16'(l), 16'(want.last_of_run));
		end
	endtask

	// Take tokens with random stalls; honor a long hold when one is requested
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				stall   = rx_hold;
				rx_hold = 0;
			end else begin
				stall = rx_nogap ? 0 : $urandom_range(0, 7);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			check_token(m_axis_tdata, m_axis_tlast);
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stuck <= 0;
		else if (arst_n)
			stuck <= stuck + 1;
		if (stuck >= STUCK_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_punctuation();
		send_text("(),;*=<>", 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_token_kinds();
		send_text("sElEcT _9 1.2.\"a\"\"\"", 1'b0);
		for (int c = CH_TAB; c <= CH_CR; c++)
			send_byte(8'(c), 1'b0);
		send_text("z", 1'b1);
	endtask

	// Nine letters: one past the keyword width, so never a keyword
	task automatic test_long_word();
		send_text("rollbackS", 1'b1);
	endtask

	// Word closed by punctuation carrying the flag: three tokens from one byte
	task automatic test_full_run();
		send_text("ab(", 1'b1);
	endtask

	task automatic test_zero_byte();
		send_text("id", 1'b0);
		send_byte(CH_NUL, 1'b0);
		send_text("zz", 1'b0);
		send_byte("A", 1'b1);
		send_byte(CH_NUL, 1'b1);
		send_text("\"ab", 1'b1);
		send_byte(CH_SPACE, 1'b1);
	endtask

	function automatic logic [7:0] pick_letter();
		return 8'($urandom_range(65, 90)) + ($urandom_range(0, 1) ? 8'h20 : 8'h00);
	endfunction

	function automatic logic [7:0] pick_word_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return pick_letter();
		if (r < 9)
			return 8'($urandom_range(48, 57));
		return CH_UNDERSCORE;
	endfunction

	task automatic test_random_queries();
		logic [7:0] qb[$];
		logic [7:0] c;
		int sent;
		int r;
		int k;
		int n;
		int e;
		sent = 0;
		while (sent < 40) begin
			qb.delete();
			tx_nogap = ($urandom_range(0, 4) == 0);
			rx_nogap = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0) begin
				// raw noise
				repeat ($urandom_range(1, 8)) qb.insert(qb.size(), 8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 6)) begin
					r = $urandom_range(0, 99);
					if (r < 30) begin
						k = $urandom_range(0, NUM_KEYWORDS - 1);
						for (int j = 0; j < kw_names[k].len(); j++) begin
							c = kw_names[k][j];
							if ($urandom_range(0, 1))
								c = c + 8'h20;
							qb.insert(qb.size(), c);
						end
					end else if (r < 45) begin
						qb.insert(qb.size(),
							($urandom_range(0, 7) == 0) ? CH_UNDERSCORE : pick_letter());
						n = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 11)
							: $urandom_range(0, 5);
						repeat (n) qb.insert(qb.size(), pick_word_char());
					end else if (r < 57) begin
						qb.insert(qb.size(), 8'($urandom_range(48, 57)));
						repeat ($urandom_range(0, 4))
							qb.insert(qb.size(), ($urandom_range(0, 3) == 0) ? CH_DOT
								: 8'($urandom_range(48, 57)));
					end else if (r < 67) begin
						qb.insert(qb.size(), CH_QUOTE);
						repeat ($urandom_range(0, 4)) begin
							c = 8'($urandom_range(1, 255));
							qb.insert(qb.size(), (c == CH_QUOTE) ? CH_SPACE : c);
						end
						if ($urandom_range(0, 9) != 0)
							qb.insert(qb.size(), CH_QUOTE);
					end else if (r < 85) begin
						qb.insert(qb.size(), punct_chars[$urandom_range(0, 7)]);
					end else begin
						qb.insert(qb.size(), 8'($urandom_range(1, 255)));
					end
					// separate with blanks most of the time
					if ($urandom_range(0, 2) != 0) begin
						r = $urandom_range(8, 13);
						qb.insert(qb.size(), (r == 8) ? CH_SPACE : 8'(r));
					end
				end
			end
			e = $urandom_range(0, 99);
			if (e < 70) begin
				foreach (qb[i])
					send_byte(qb[i], i == qb.size() - 1);
				sent += qb.size();
			end else if (e < 85) begin
				// zero byte ends the query, trailing bytes are dropped until the flag
				qb.insert(qb.size(), CH_NUL);
				foreach (qb[i])
					send_byte(qb[i], 1'b0);
				sent += qb.size();
				repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				qb.insert(qb.size(), CH_NUL);
				foreach (qb[i])
					send_byte(qb[i], i == qb.size() - 1);
				sent += qb.size();
			end
		end
		tx_nogap = 1'b0;
		rx_nogap = 1'b0;
	endtask

	// Stall the output long enough for the block to fill and stop taking bytes
	task automatic test_backpressure();
		tx_nogap = 1'b1;
		rx_hold  = HOLD_CYCLES;
		repeat (8) send_text("a(", 1'b0);
		send_text("b)", 1'b1);
		tx_nogap = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		clear_lexer();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_punctuation();
		test_token_kinds();
		test_long_word();
		test_full_run();
		test_zero_byte();
		test_random_queries();
		test_backpressure();

		s_axis_tvalid <= 1'b0;
		while (token_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
src/sqt_pkg.sv
src/sqt_lexer.sv
src/sqt_outbuf.sv
src/sql_query_tokenizer_core.sv
tb/sql_query_tokenizer_core_tb.sv
